@@ sv/tffa_pkg.sv @@
// shared types and constants for the tx fifo frame assembler
// no dependencies
package tffa_pkg;

  localparam int unsigned FRAME_BUFFER_BYTES_DEF = 2048;
  localparam int unsigned QUEUE_DEPTH_DEF        = 2;

  localparam logic [11:0] CAPACITY_RESET = 12'd1152;

  localparam logic [31:0] CMDA_MASK  = 32'h831f_37ff;
  localparam int unsigned CMDA_LAST  = 12;
  localparam int unsigned CMDA_FIRST = 13;
  localparam int unsigned CMDA_IOC   = 31;
  localparam int unsigned SIZE_W     = 11;
  localparam int unsigned SKIP_LSB   = 16;
  localparam int unsigned ALIGN_LSB  = 24;

  localparam logic [1:0] ALIGN_16 = 2'd1;
  localparam logic [1:0] ALIGN_32 = 2'd2;

  typedef enum logic {
    OP_PUSH    = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_CMDB = 2'd1,
    PH_DATA = 2'd2
  } phase_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] word;
    logic [31:0] cmda;
  } cmd_item_t;

  typedef struct packed {
    logic        overflow_int;
    logic        completion_int;
    logic [31:0] data_bytes;
    logic [2:0]  byte_count;
    logic [11:0] write_index;
    logic        send_frame;
    logic [11:0] frame_length;
    logic [31:0] frame_tag_word;
  } result_t;

endpackage

@@ sv/tffa_fifo.sv @@
// small registered queue with valid/ready on both sides
// no dependencies
module tffa_fifo #(
  parameter int unsigned DATA_W = 32,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push_valid,
  output logic              push_ready,
  input  logic [DATA_W-1:0] push_data,
  output logic              pop_valid,
  input  logic              pop_ready,
  output logic [DATA_W-1:0] pop_data
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("empty queue with pointers apart");

endmodule

@@ sv/tffa_front.sv @@
// front end: accepts items, decodes the command a view of each word, queues it
// depends on tffa_pkg and tffa_fifo
module tffa_front #(
  parameter int unsigned QUEUE_DEPTH = tffa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_cmd,
  input  logic [31:0]          in_word,
  output logic                 q_valid,
  input  logic                 q_ready,
  output tffa_pkg::cmd_item_t  q_item
);

  import tffa_pkg::*;

  cmd_item_t item;
  logic [$bits(cmd_item_t)-1:0] q_bits;

  always_comb begin
    item.op   = in_cmd ? OP_RELEASE : OP_PUSH;
    item.word = in_word;
    item.cmda = in_word & CMDA_MASK;
  end

  tffa_fifo #(
    .DATA_W ($bits(cmd_item_t)),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (item),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_bits)
  );

  assign q_item = cmd_item_t'(q_bits);

endmodule

@@ sv/tffa_back.sv @@
// back end: command parser state, fifo fill tracking and byte emission
// depends on tffa_pkg
module tffa_back #(
  parameter int unsigned FRAME_BUFFER_BYTES = tffa_pkg::FRAME_BUFFER_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [11:0]          cfg_wr_data,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  tffa_pkg::cmd_item_t  q_item,
  output logic                 res_valid,
  input  logic                 res_ready,
  output tffa_pkg::result_t    res
);

  import tffa_pkg::*;

  localparam int unsigned FB_W = $clog2(FRAME_BUFFER_BYTES + 1);
  localparam logic [FB_W-1:0] FB_MAX = FB_W'(FRAME_BUFFER_BYTES);

  phase_t                  phase_r, phase_nxt;
  logic [11:0]             capacity_r;
  logic [31:0]             command_a_r, command_a_nxt;
  logic [31:0]             command_b_r, command_b_nxt;
  logic signed [12:0]      bytes_left_r, bytes_left_nxt;
  logic [4:0]              start_skip_r, start_skip_nxt;
  logic [2:0]              pad_words_r, pad_words_nxt;
  logic [FB_W-1:0]         frame_bytes_r, frame_bytes_nxt;
  logic [11:0]             words_used_r, words_used_nxt;

  logic                    step, full, push_ok, finish;
  logic [12:0]             word_sum;
  logic [10:0]             n_words;
  logic [1:0]              skip_lo;
  logic [2:0]              cnt;
  logic signed [12:0]      bl_sub;
  logic [FB_W:0]           fb_sum;

  assign step    = q_valid && res_ready;
  assign q_ready = res_ready;
  assign res_valid = q_valid;
  assign full    = (words_used_r >= capacity_r);
  assign push_ok = step && (q_item.op == OP_PUSH) && !full;

  // phase sequencing
  always_comb begin
    phase_nxt = phase_r;
    unique case (phase_r)
      PH_CMDB: begin
        if (push_ok) phase_nxt = PH_DATA;
      end
      PH_DATA: begin
        if (push_ok && finish) phase_nxt = PH_IDLE;
      end
      default: begin
        if (push_ok) phase_nxt = PH_CMDB;
      end
    endcase
  end

  // datapath and result
  always_comb begin
    command_a_nxt   = command_a_r;
    command_b_nxt   = command_b_r;
    bytes_left_nxt  = bytes_left_r;
    start_skip_nxt  = start_skip_r;
    pad_words_nxt   = pad_words_r;
    frame_bytes_nxt = frame_bytes_r;
    words_used_nxt  = words_used_r;
    finish          = 1'b0;
    res             = '0;

    word_sum = 13'(command_a_r[SIZE_W-1:0]) + 13'(start_skip_r) + 13'd3;
    n_words  = word_sum[12:2];
    skip_lo  = start_skip_r[1:0];
    cnt      = 3'd4 - {1'b0, skip_lo};
    bl_sub   = bytes_left_r - $signed({10'd0, cnt});
    fb_sum   = {1'b0, frame_bytes_r} + (FB_W + 1)'(cnt);

    if (step && q_item.op == OP_RELEASE) begin
      words_used_nxt = (q_item.word >= {20'd0, words_used_r}) ? '0
                       : words_used_r - q_item.word[11:0];
    end else if (step && full) begin
      res.overflow_int = 1'b1;
    end else if (step) begin
      unique case (phase_r)
        PH_CMDB: begin
          if (command_a_r[CMDA_FIRST]) begin
            command_b_nxt  = q_item.word;
            words_used_nxt = words_used_r + 1'b1;
            frame_bytes_nxt = '0;
            case (command_a_r[ALIGN_LSB +: 2])
              ALIGN_16: pad_words_nxt = (3'd0 - {1'b0, n_words[1:0]}) & 3'b011;
              ALIGN_32: pad_words_nxt = 3'd0 - n_words[2:0];
              default:  pad_words_nxt = 3'd0;
            endcase
          end
        end
        PH_DATA: begin
          if (start_skip_r >= 5'd4) begin
            start_skip_nxt = start_skip_r - 5'd4;
          end else begin
            if (bytes_left_r <= 0 && pad_words_r != 3'd0) begin
              pad_words_nxt = pad_words_r - 1'b1;
            end else begin
              case (skip_lo)
                2'd1:    res.data_bytes = {8'd0, q_item.word[31:8]};
                2'd2:    res.data_bytes = {16'd0, q_item.word[31:16]};
                2'd3:    res.data_bytes = {24'd0, q_item.word[31:24]};
                default: res.data_bytes = q_item.word;
              endcase
              res.byte_count  = cnt;
              res.write_index = 12'(frame_bytes_r);
              start_skip_nxt  = '0;
              frame_bytes_nxt = (fb_sum > {1'b0, FB_MAX}) ? FB_MAX : fb_sum[FB_W-1:0];
              bytes_left_nxt  = (bl_sub < -13'sd4) ? -13'sd4 : bl_sub;
              words_used_nxt  = words_used_r + 1'b1;
            end
            if (bytes_left_nxt <= 0 && pad_words_nxt == 3'd0) begin
              finish = 1'b1;
              if (command_a_r[CMDA_LAST]) begin
                res.send_frame     = 1'b1;
                res.frame_length   = 12'(frame_bytes_nxt);
                res.frame_tag_word = command_b_r;
              end
              res.completion_int = command_a_r[CMDA_IOC];
            end
          end
        end
        default: begin
          command_a_nxt  = q_item.cmda;
          words_used_nxt = words_used_r + 1'b1;
          bytes_left_nxt = $signed({2'b00, q_item.cmda[SIZE_W-1:0]});
          start_skip_nxt = q_item.cmda[SKIP_LSB +: 5];
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      capacity_r    <= CAPACITY_RESET;
      command_a_r   <= '0;
      command_b_r   <= '0;
      bytes_left_r  <= '0;
      start_skip_r  <= '0;
      pad_words_r   <= '0;
      frame_bytes_r <= '0;
      words_used_r  <= '0;
    end else begin
      phase_r       <= phase_nxt;
      if (cfg_wr_en) capacity_r <= cfg_wr_data;
      command_a_r   <= command_a_nxt;
      command_b_r   <= command_b_nxt;
      bytes_left_r  <= bytes_left_nxt;
      start_skip_r  <= start_skip_nxt;
      pad_words_r   <= pad_words_nxt;
      frame_bytes_r <= frame_bytes_nxt;
      words_used_r  <= words_used_nxt;
    end
  end

  a_ovf_alone: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.overflow_int) |-> (res.byte_count == 3'd0 && !res.send_frame))
    else $error("overflow result carries payload");

  a_send_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res.send_frame) |=> (phase_r == PH_IDLE))
    else $error("frame sent without return to idle");

  a_bytes_floor: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_left_r >= -13'sd4)
    else $error("bytes left below floor");

endmodule

@@ sv/tx_fifo_frame_assembler.sv @@
// tx fifo frame assembler: an accepted item waits in the registered front queue and
// its result in the registered result queue before it is offered at the output
// throughput one item per cycle while the result queue has room (combinational parser)
// front queue and result queue each hold QUEUE_DEPTH items (2 by default), so either side may stall alone
// synchronous active-low reset: parser idle, counters zero, capacity 1152 words
// depends on tffa_pkg, tffa_front, tffa_back and tffa_fifo
module tx_fifo_frame_assembler #(
  parameter int unsigned FRAME_BUFFER_BYTES = tffa_pkg::FRAME_BUFFER_BYTES_DEF,
  parameter int unsigned QUEUE_DEPTH        = tffa_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [11:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_overflow_int,
  output logic        out_completion_int,
  output logic [31:0] out_data_bytes,
  output logic [2:0]  out_byte_count,
  output logic [11:0] out_write_index,
  output logic        out_send_frame,
  output logic [11:0] out_frame_length,
  output logic [31:0] out_frame_tag_word
);

  import tffa_pkg::*;

  cmd_item_t q_item;
  logic      q_valid, q_ready;
  result_t   res, out_res;
  logic      res_valid, res_ready;
  logic [$bits(result_t)-1:0] out_bits;

  tffa_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_cmd   (in_cmd),
    .in_word  (in_word),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .q_item   (q_item)
  );

  tffa_back #(
    .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  tffa_fifo #(
    .DATA_W ($bits(result_t)),
    .DEPTH  (QUEUE_DEPTH)
  ) u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (res_valid),
    .push_ready (res_ready),
    .push_data  (res),
    .pop_valid  (out_valid),
    .pop_ready  (out_ready),
    .pop_data   (out_bits)
  );

  assign out_res            = result_t'(out_bits);
  assign out_overflow_int   = out_res.overflow_int;
  assign out_completion_int = out_res.completion_int;
  assign out_data_bytes     = out_res.data_bytes;
  assign out_byte_count     = out_res.byte_count;
  assign out_write_index    = out_res.write_index;
  assign out_send_frame     = out_res.send_frame;
  assign out_frame_length   = out_res.frame_length;
  assign out_frame_tag_word = out_res.frame_tag_word;

endmodule

@@ verif/tb_top.sv @@
// self-checking testbench for tx_fifo_frame_assembler: directed buffers, overflow,
// masked command words and random command/data traffic, mostly under random stalls
// depends on tffa_pkg and the tx_fifo_frame_assembler rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import tffa_pkg::*;

  localparam int unsigned FRAME_BYTES_MAX = FRAME_BUFFER_BYTES_DEF;
  localparam logic [1:0]  ALIGN_NONE      = 2'd0;
  localparam logic [1:0]  ALIGN_RSVD      = 2'd3;
  localparam int          WATCHDOG_LIMIT  = 2000;
  localparam int          SETTLE_CYCLES   = 4;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [11:0] cfg_wr_data;
  logic        in_valid;
  logic        in_ready;
  logic        in_cmd;
  logic [31:0] in_word;
  logic        out_valid;
  logic        out_ready;
  logic        out_overflow_int;
  logic        out_completion_int;
  logic [31:0] out_data_bytes;
  logic [2:0]  out_byte_count;
  logic [11:0] out_write_index;
  logic        out_send_frame;
  logic [11:0] out_frame_length;
  logic [31:0] out_frame_tag_word;

  // parser state as the testbench sees it
  logic [11:0] capacity    = CAPACITY_RESET;
  phase_t      ph          = PH_IDLE;
  logic [31:0] cmd_a       = '0;
  logic [31:0] cmd_b       = '0;
  int          bytes_left  = 0;
  logic [4:0]  start_skip  = '0;
  logic [2:0]  pad_words   = '0;
  int unsigned frame_bytes = 0;
  logic [31:0] words_used  = '0;

  result_t     expected_q[$];
  int unsigned items_sent = 0;
  int unsigned err_count  = 0;
  bit          idling     = 1'b1;

  tx_fifo_frame_assembler u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_word           (in_word),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_overflow_int  (out_overflow_int),
    .out_completion_int(out_completion_int),
    .out_data_bytes    (out_data_bytes),
    .out_byte_count    (out_byte_count),
    .out_write_index   (out_write_index),
    .out_send_frame    (out_send_frame),
    .out_frame_length  (out_frame_length),
    .out_frame_tag_word(out_frame_tag_word)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned frame_sat(input int unsigned v);
    return (v > FRAME_BYTES_MAX) ? FRAME_BYTES_MAX : v;
  endfunction

  function automatic result_t assemble_step(input op_t op, input logic [31:0] w);
    result_t     r;
    logic [31:0] n;
    logic [1:0]  skip;
    r = '0;
    if (op == OP_RELEASE) begin
      words_used = (w >= words_used) ? 32'd0 : words_used - w;
    end else if (words_used >= capacity) begin
      r.overflow_int = 1'b1;
    end else if (ph == PH_CMDB) begin
      if (cmd_a[CMDA_FIRST]) begin
        cmd_b = w;
        words_used++;
        n = (unsigned'(bytes_left) + start_skip + 32'd3) >> 2;
        case (cmd_a[ALIGN_LSB +: 2])
          ALIGN_16: pad_words = 3'((32'd0 - n) & 32'd3);
          ALIGN_32: pad_words = 3'((32'd0 - n) & 32'd7);
          default:  pad_words = '0;
        endcase
        frame_bytes = 0;
      end
      ph = PH_DATA;
    end else if (ph == PH_DATA) begin
      if (start_skip >= 5'd4) begin
        start_skip = start_skip - 5'd4;
      end else begin
        if (bytes_left <= 0 && pad_words != 0) begin
          pad_words--;
        end else begin
          skip = start_skip[1:0];
          r.data_bytes = w >> (8 * skip);
          r.byte_count = 3'd4 - {1'b0, skip};
          start_skip = '0;
          r.write_index = 12'(frame_sat(frame_bytes));
          frame_bytes = frame_sat(frame_bytes + r.byte_count);
          bytes_left = bytes_left - int'(r.byte_count);
          if (bytes_left < -4) bytes_left = -4;
          words_used++;
        end
        if (bytes_left <= 0 && pad_words == 0) begin
          if (cmd_a[CMDA_LAST]) begin
            r.send_frame = 1'b1;
            r.frame_length = 12'(frame_bytes);
            r.frame_tag_word = cmd_b;
          end
          if (cmd_a[CMDA_IOC]) r.completion_int = 1'b1;
          ph = PH_IDLE;
        end
      end
    end else begin
      cmd_a = w & CMDA_MASK;
      words_used++;
      ph = PH_CMDB;
      bytes_left = int'(cmd_a[SIZE_W-1:0]);
      start_skip = cmd_a[SKIP_LSB +: 5];
    end
    return r;
  endfunction

  function automatic logic [31:0] make_cmd_a(input int size, input int skip,
                                             input logic [1:0] align, input bit first,
                                             input bit last, input bit ioc);
    logic [31:0] a;
    a = '0;
    a[SIZE_W-1:0] = size[SIZE_W-1:0];
    a[SKIP_LSB +: 5] = skip[4:0];
    a[ALIGN_LSB +: 2] = align;
    a[CMDA_FIRST] = first;
    a[CMDA_LAST] = last;
    a[CMDA_IOC] = ioc;
    return a;
  endfunction

  task automatic report_mismatch(input string what);
    err_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  task automatic send_item(input op_t op, input logic [31:0] w);
    if (idling && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd <= op;
    in_word <= w;
    do begin
      @(posedge clk);
    end while (!in_ready);
    expected_q.push_back(assemble_step(op, w));
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [11:0] v);
    drain_results();
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    capacity = v;
  endtask

  task automatic push_until_idle(input int max_words);
    while (ph != PH_IDLE && max_words > 0) begin
      send_item(OP_PUSH, $urandom());
      max_words--;
    end
  endtask

  task automatic send_random_frame();
    logic [31:0] a;
    int          words_left;
    a = $urandom();
    if ($urandom_range(0, 9) < 9) a[SIZE_W-1:0] = 11'($urandom_range(0, 48));
    else a[SIZE_W-1:0] = 11'($urandom_range(49, 300));
    if ($urandom_range(0, 7) != 0) a[CMDA_FIRST] = 1'b1;
    send_item(OP_PUSH, a);
    send_item(OP_PUSH, $urandom());
    words_left = bytes_left + int'(start_skip);
    if (words_left < 0) words_left = 0;
    words_left = words_left / 4 + 12;
    // broken buffer: cut the data short
    if ($urandom_range(0, 9) == 0) words_left = $urandom_range(0, words_left);
    while (ph == PH_DATA && words_left > 0) begin
      if ($urandom_range(0, 9) == 0) send_item(OP_RELEASE, $urandom_range(0, 24));
      else send_item(OP_PUSH, $urandom());
      words_left--;
    end
  endtask

  task automatic test_directed_frames();
    // first and last with offset byte, 16 byte alignment and completion interrupt
    send_item(OP_PUSH, make_cmd_a(5, 1, ALIGN_16, 1'b1, 1'b1, 1'b1));
    send_item(OP_PUSH, 32'ha5a5_0001);
    send_item(OP_PUSH, 32'hffff_ffff);
    send_item(OP_PUSH, 32'h0000_0000);
    push_until_idle(4);
    send_item(OP_RELEASE, 32'h0000_0000);
    send_item(OP_RELEASE, 32'hffff_ffff);
    // whole offset word, 32 byte alignment, no last
    send_item(OP_PUSH, make_cmd_a(3, 6, ALIGN_32, 1'b1, 1'b0, 1'b0));
    send_item(OP_PUSH, 32'h1234_5678);
    push_until_idle(12);
    // later segment: command b ignored, length carries on
    send_item(OP_PUSH, make_cmd_a(1, 0, ALIGN_NONE, 1'b0, 1'b1, 1'b0));
    send_item(OP_PUSH, 32'hdead_beef);
    push_until_idle(4);
    // zero size buffer still takes one data word
    send_item(OP_PUSH, make_cmd_a(0, 0, ALIGN_RSVD, 1'b1, 1'b1, 1'b1));
    send_item(OP_PUSH, 32'h0000_0000);
    push_until_idle(4);
  endtask

  task automatic test_overflow();
    write_capacity(12'd0);
    send_item(OP_PUSH, 32'h0000_0000);
    send_item(OP_RELEASE, 32'h0000_0001);
    write_capacity(12'd2);
    send_item(OP_RELEASE, 32'hffff_ffff);
    send_item(OP_PUSH, make_cmd_a(4, 0, ALIGN_NONE, 1'b1, 1'b1, 1'b0));
    send_item(OP_PUSH, 32'hcafe_f00d);
    send_item(OP_PUSH, 32'hcafe_f00d);
    send_item(OP_RELEASE, 32'h0000_0001);
    push_until_idle(4);
    write_capacity(CAPACITY_RESET);
  endtask

  task automatic test_frame_buffer_bound();
    send_item(OP_RELEASE, 32'hffff_ffff);
    // every command a bit set apart from a short size: largest offset, masked bits
    send_item(OP_PUSH, 32'hffff_f8c8);
    send_item(OP_PUSH, $urandom());
    push_until_idle(80);
    send_item(OP_PUSH, make_cmd_a(8, 0, ALIGN_NONE, 1'b0, 1'b1, 1'b1));
    send_item(OP_PUSH, $urandom());
    push_until_idle(8);
    send_item(OP_RELEASE, 32'hffff_ffff);
  endtask

  task automatic test_random_traffic();
    logic [11:0] caps[5];
    int          quota[5];
    int unsigned stop_at;
    caps = '{12'd4095, 12'd16, 12'($urandom_range(1, 4094)), 12'd0, CAPACITY_RESET};
    quota = '{70, 70, 70, 10, 110};
    for (int p = 0; p < 5; p++) begin
      write_capacity(caps[p]);
      if (p == 4) idling = 1'b0;
      stop_at = items_sent + quota[p];
      while (items_sent < stop_at) begin
        case ($urandom_range(0, 7))
          0, 1: begin
            send_item(OP_RELEASE,
                      ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 80));
          end
          2: begin
            send_item(OP_PUSH, $urandom());
          end
          default: begin
            send_random_frame();
          end
        endcase
      end
    end
  endtask

  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("result item with nothing expected");
      end else begin
        want = expected_q.pop_front();
        compare_field("overflow_int", 32'(out_overflow_int), 32'(want.overflow_int));
        compare_field("completion_int", 32'(out_completion_int), 32'(want.completion_int));
        compare_field("data_bytes", out_data_bytes, want.data_bytes);
        compare_field("byte_count", 32'(out_byte_count), 32'(want.byte_count));
        compare_field("write_index", 32'(out_write_index), 32'(want.write_index));
        compare_field("send_frame", 32'(out_send_frame), 32'(want.send_frame));
        compare_field("frame_length", 32'(out_frame_length), 32'(want.frame_length));
        compare_field("frame_tag_word", out_frame_tag_word, want.frame_tag_word);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin : run
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= 1'b0;
    in_word <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_frames();
    test_overflow();
    test_frame_buffer_bound();
    test_random_traffic();
    drain_results();
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
